[rtl/core/bhll_pkg.sv]
// Shared types, constants and helper functions for the byte histogram with
// line length tracking. No dependencies; imported by every module but bhll_ram.
`default_nettype none

package bhll_pkg;

  // Count width of the bins and line counters (8 to 64)
  localparam int COUNT_WIDTH = 32;
  localparam int OUT_W       = 32;
  localparam int NUM_BINS    = 256;
  localparam int BIN_AW      = $clog2(NUM_BINS);
  localparam int SEL_W       = 9;

  // Command queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Operation codes on the input channel
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_FEED  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Line terminators
  localparam logic [7:0] BYTE_NUL = 8'd0;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] BYTE_CR  = 8'd13;

  // Read select of the longest line register
  localparam logic [SEL_W-1:0] SEL_MAX_LINE = SEL_W'(NUM_BINS);

  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef logic [COUNT_WIDTH-1:0] cnt_t;
  localparam cnt_t CNT_MAX = {COUNT_WIDTH{1'b1}};

  // Classified command kinds
  typedef enum logic [2:0] {
    K_CLEAR,
    K_FEED,
    K_RD_BIN,
    K_RD_MAX,
    K_RD_ZERO
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BIN_AW-1:0] addr;
    logic              term;
  } item_t;

  // Saturating increment
  function automatic cnt_t sat_inc(cnt_t v);
    cnt_t r;
    if (v == CNT_MAX) r = v;
    else              r = v + cnt_t'(1);
    return r;
  endfunction

  // Clamp a count to the output width
  function automatic logic [OUT_W-1:0] to_out(cnt_t v);
    logic [63:0] w;
    logic [OUT_W-1:0] r;
    w = 64'(v);
    if (w > 64'(OUT_MAX)) r = OUT_MAX;
    else                  r = w[OUT_W-1:0];
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/core/bhll_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module bhll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/bhll_front.sv]
// Front end: accepts input beats, classifies them into commands and queues
// them for the back end. Depends on bhll_pkg.
`default_nettype none

module bhll_front
  import bhll_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_operation,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic [SEL_W-1:0] in_read_bin,
  output logic                  q_valid,
  output item_t                 q_item,
  input  wire logic             q_pop
);

  item_t           mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] cnt_r, cnt_nxt;
  item_t           cls;
  logic            keep;
  logic            push;

  // classify the incoming beat; unused opcode is accepted and dropped
  always_comb begin
    cls      = '0;
    cls.kind = K_CLEAR;
    keep     = 1'b1;
    case (in_operation)
      OP_CLEAR: begin
        cls.kind = K_CLEAR;
      end
      OP_FEED: begin
        cls.kind = K_FEED;
        cls.addr = in_data_byte;
        cls.term = (in_data_byte == BYTE_NUL) || (in_data_byte == BYTE_LF) ||
                   (in_data_byte == BYTE_CR);
      end
      OP_READ: begin
        cls.addr = in_read_bin[BIN_AW-1:0];
        if (in_read_bin < SEL_MAX_LINE)       cls.kind = K_RD_BIN;
        else if (in_read_bin == SEL_MAX_LINE) cls.kind = K_RD_MAX;
        else                                  cls.kind = K_RD_ZERO;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall = (cnt_r == Q_CW'(Q_DEPTH));
  assign push     = in_valid && !in_stall && keep;
  assign q_valid  = (cnt_r != '0);
  assign q_item   = mem_r[rd_ptr_r];

  // queue pointers
  always_comb begin
    wr_ptr_nxt = push  ? wr_ptr_r + Q_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = q_pop ? rd_ptr_r + Q_AW'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + Q_CW'(push) - Q_CW'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule

`default_nettype wire

[rtl/core/bhll_back.sv]
// Back end: executes queued commands against the bin RAM and line counters,
// and holds the result register. Depends on bhll_pkg and bhll_ram.
`default_nettype none

module bhll_back
  import bhll_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_valid,
  input  wire item_t            q_item,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [OUT_W-1:0] out_count_value
);

  typedef enum logic {ST_IDLE, ST_RD} state_t;

  state_t            state_r, state_nxt;
  kind_t             kind_r, kind_nxt;
  logic [BIN_AW-1:0] addr_r, addr_nxt;
  logic [NUM_BINS-1:0] vld_r, vld_nxt;
  cnt_t              line_r, line_nxt;
  cnt_t              longest_r, longest_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]  out_data_r, out_data_nxt;
  logic              ram_we;
  cnt_t              ram_wdata;
  cnt_t              ram_rdata;
  cnt_t              cur;
  logic              is_read;
  logic              out_load;

  bhll_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .re    (q_pop),
    .raddr (q_item.addr),
    .rdata (ram_rdata)
  );

  // reads wait for a free result register
  assign is_read = (q_item.kind == K_RD_BIN) || (q_item.kind == K_RD_MAX) ||
                   (q_item.kind == K_RD_ZERO);
  assign q_pop   = q_valid && (state_r == ST_IDLE) && !(is_read && out_valid_r);

  // bin value, never-written bins read as zero
  assign cur       = vld_r[addr_r] ? ram_rdata : '0;
  assign ram_we    = (state_r == ST_RD) && (kind_r == K_FEED);
  assign ram_wdata = sat_inc(cur);

  // command sequencing
  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    addr_nxt      = addr_r;
    vld_nxt       = vld_r;
    line_nxt      = line_r;
    longest_nxt   = longest_r;
    out_data_nxt  = out_data_r;
    out_load      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          kind_nxt = q_item.kind;
          addr_nxt = q_item.addr;
          case (q_item.kind)
            K_CLEAR: begin
              vld_nxt     = '0;
              line_nxt    = '0;
              longest_nxt = '0;
            end
            K_FEED: begin
              if (line_r > longest_r) longest_nxt = line_r;
              line_nxt  = q_item.term ? '0 : sat_inc(line_r);
              state_nxt = ST_RD;
            end
            K_RD_BIN: begin
              state_nxt = ST_RD;
            end
            K_RD_MAX: begin
              out_load     = 1'b1;
              out_data_nxt = to_out(longest_r);
            end
            default: begin
              out_load     = 1'b1;
              out_data_nxt = '0;
            end
          endcase
        end
      end
      ST_RD: begin
        state_nxt = ST_IDLE;
        if (kind_r == K_FEED) begin
          vld_nxt[addr_r] = 1'b1;
        end else begin
          out_load     = 1'b1;
          out_data_nxt = to_out(cur);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vld_r       <= '0;
      line_r      <= '0;
      longest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vld_r       <= vld_nxt;
      line_r      <= line_nxt;
      longest_r   <= longest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r     <= kind_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_count_value = out_data_r;

  // checks
  a_we_in_rd: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_RD))
    else $error("bin write outside read-modify-write step");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == ST_IDLE))
    else $error("command popped while busy");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> !out_valid_r)
    else $error("result overwrote a pending beat");

  a_longest: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && q_item.kind == K_FEED) |=> (longest_r >= $past(line_r)))
    else $error("longest line below line counter after feed");

endmodule

`default_nettype wire

[rtl/core/byte_histogram_line_length.sv]
// Byte histogram with longest line tracking.
//
// Input channel (in_valid / in_stall): one beat carries in_operation,
// in_data_byte and in_read_bin. Operation 0 clears all bins and both line
// counters, 1 counts in_data_byte into its bin and advances the line
// counter (reset by NUL, LF or CR), 2 reads a bin (0..255) or the longest
// line (256); higher selects read zero. Operation 3 is taken and ignored.
// Output channel (out_valid / out_stall): one beat per read, out_count_value,
// counts saturate and are clamped to 32 bits.
// Beats enter a 4-deep command queue and are executed one at a time by the
// back end: a feed or bin read has two steps (bin RAM read, then write or
// result load), a clear, longest-line read or out-of-range read has one.
// With an empty queue a bin read passes the queue, the bin RAM read and the
// result register; a longest-line or out-of-range read skips the RAM read.
// Each byte's bin read-modify-write ends before the next command starts.
// Reset (rst_n low, synchronous) empties the queue and marks every bin
// zero at once; no clearing pass. While out_stall is high a result holds,
// later reads wait, and the queue fills until in_stall rises.
// Depends on bhll_pkg, bhll_front, bhll_back and bhll_ram.
`default_nettype none

module byte_histogram_line_length
  import bhll_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [1:0]       in_operation,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic [SEL_W-1:0] in_read_bin,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic      [OUT_W-1:0] out_count_value
);

  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  bhll_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .in_data_byte (in_data_byte),
    .in_read_bin  (in_read_bin),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop)
  );

  bhll_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count_value (out_count_value)
  );

endmodule

`default_nettype wire

[verif/bhll_checker.sv]
// Checker for the byte histogram: watches both channels, keeps its own copy of
// the bins and line counters, and compares every read beat in order.
// Depends on bhll_pkg for widths, operation codes and terminator bytes.

module bhll_checker
  import bhll_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [1:0]       in_operation,
  input  logic [7:0]       in_data_byte,
  input  logic [SEL_W-1:0] in_read_bin,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [OUT_W-1:0] out_count_value,
  output int               miss_count,
  output int               reads_pending
);

  localparam int DUE_DEPTH = 1024;

  // Shadow histogram and line counters
  cnt_t tally [NUM_BINS];
  cnt_t line_run;
  cnt_t longest_run;

  // Read values still owed by the block, oldest at due_head
  logic [OUT_W-1:0] reads_due [DUE_DEPTH];
  int               due_head;
  int               due_tail;

  function automatic cnt_t bump(cnt_t v);
    return (v == CNT_MAX) ? v : v + 1'b1;
  endfunction

  task automatic zero_counts();
    foreach (tally[i]) tally[i] = '0;
    line_run    = '0;
    longest_run = '0;
  endtask

  task automatic log_miss(string msg);
    miss_count++;
    if (miss_count <= 10) $display("checker: %s", msg);
  endtask

  always @(posedge clk) begin : track
    logic [OUT_W-1:0] want;
    logic [63:0]      wide;
    if (!rst_n) begin
      zero_counts();
      due_head      = 0;
      due_tail      = 0;
      miss_count    = 0;
      reads_pending <= 0;
    end else begin
      // Result beat: match against the oldest outstanding read
      if (out_valid && !out_stall) begin
        if (due_tail == due_head) begin
          log_miss($sformatf("unexpected read beat, expected none, got %0d",
                             out_count_value));
        end else begin
          want = reads_due[due_head % DUE_DEPTH];
          due_head++;
          if (out_count_value !== want)
            log_miss($sformatf("read mismatch: expected %0d, got %0d",
                               want, out_count_value));
        end
      end

      // Input beat: update the shadow state, queue a value for reads
      if (in_valid && !in_stall) begin
        case (in_operation)
          OP_CLEAR: begin
            zero_counts();
          end
          OP_FEED: begin
            tally[in_data_byte] = bump(tally[in_data_byte]);
            // longest line is sampled before this byte moves the counter
            if (line_run > longest_run) longest_run = line_run;
            if (in_data_byte == BYTE_NUL || in_data_byte == BYTE_LF ||
                in_data_byte == BYTE_CR)
              line_run = '0;
            else
              line_run = bump(line_run);
          end
          OP_READ: begin
            if (in_read_bin < NUM_BINS)
              wide = 64'(tally[in_read_bin[BIN_AW-1:0]]);
            else if (in_read_bin == SEL_MAX_LINE)
              wide = 64'(longest_run);
            else
              wide = '0;
            // clamp wide counts to the output width
            want = ((wide >> OUT_W) != 0) ? OUT_MAX : wide[OUT_W-1:0];
            if (due_tail - due_head >= DUE_DEPTH) begin
              log_miss($sformatf("too many reads outstanding, expected %0d, got %0d",
                                 DUE_DEPTH - 1, due_tail - due_head));
            end else begin
              reads_due[due_tail % DUE_DEPTH] = want;
              due_tail++;
            end
          end
          default: begin
            // spare opcode: taken, no effect
          end
        endcase
      end
      reads_pending <= due_tail - due_head;
    end
  end

endmodule

[verif/tb.sv]
// Top of the byte histogram testbench: clock, reset, stimulus and verdict.
// Drives directed and random beats with random idling on both channels;
// depends on bhll_pkg, the block and bhll_checker.

module tb;
  import bhll_pkg::*;

  localparam logic [1:0] OP_SPARE      = 2'd3;
  localparam int         RANDOM_BEATS  = 830;
  localparam int         TAIL_BEATS    = 100;
  localparam int         PAUSE_AT      = 400;
  localparam int         SETTLE_CYCLES = 12;
  localparam int         CYCLE_LIMIT   = 200000;

  logic             clk             = 1'b0;
  logic             rst_n           = 1'b0;
  logic             in_valid        = 1'b0;
  logic             in_stall;
  logic [1:0]       in_operation    = OP_CLEAR;
  logic [7:0]       in_data_byte    = '0;
  logic [SEL_W-1:0] in_read_bin     = '0;
  logic             out_valid;
  logic             out_stall       = 1'b0;
  logic [OUT_W-1:0] out_count_value;

  bit calm       = 1'b0;
  int gap_odds   = 4;
  int stall_left = 0;
  int cycles     = 0;
  int miss_count;
  int reads_pending;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  byte_histogram_line_length dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .in_read_bin     (in_read_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count_value (out_count_value)
  );

  bhll_checker chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_data_byte    (in_data_byte),
    .in_read_bin     (in_read_bin),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_count_value (out_count_value),
    .miss_count      (miss_count),
    .reads_pending   (reads_pending)
  );

  // Result side: random bursts of stall or free run, none in the tail
  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      out_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= $urandom_range(1, 10);
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // One beat on the input channel, with an optional idle burst ahead of it
  task automatic send_beat(input logic [1:0] op, input logic [7:0] b,
                           input logic [SEL_W-1:0] sel);
    if (!calm && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_data_byte <= b;
    in_read_bin  <= sel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Hold the input idle until every read has come back
  task automatic drain_reads();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reads_pending != 0) @(posedge clk);
  endtask

  // Text-like byte; with may_break, terminators and raw bytes mixed in
  function automatic logic [7:0] text_byte(bit may_break);
    int r;
    r = $urandom_range(0, 99);
    if (may_break && r < 12) begin
      case (r % 3)
        0:       return BYTE_NUL;
        1:       return BYTE_LF;
        default: return BYTE_CR;
      endcase
    end
    if (may_break && r < 22) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(32, 126));
  endfunction

  initial begin : stimulus
    int               n;
    int               r;
    int               run_len;
    bit               paused;
    logic [SEL_W-1:0] sel;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty reads, short lines, terminators, unterminated tail
    send_beat(OP_READ, 8'hFF, '0);
    send_beat(OP_READ, 8'h00, SEL_MAX_LINE);
    send_beat(OP_READ, 8'h00, '1);
    repeat (3) send_beat(OP_FEED, 8'h41, '0);
    send_beat(OP_FEED, 8'hFF, '1);
    send_beat(OP_FEED, BYTE_LF, '0);
    send_beat(OP_READ, 8'h00, SEL_W'(8'h41));
    send_beat(OP_READ, 8'h00, SEL_MAX_LINE);
    send_beat(OP_FEED, 8'h62, '0);
    send_beat(OP_FEED, BYTE_CR, '0);
    send_beat(OP_FEED, BYTE_NUL, '0);
    send_beat(OP_FEED, 8'h78, '0);
    send_beat(OP_FEED, 8'h79, '0);
    send_beat(OP_READ, 8'h00, SEL_MAX_LINE);
    send_beat(OP_READ, 8'h00, SEL_W'(8'hFF));
    send_beat(OP_READ, 8'h00, SEL_W'(BYTE_NUL));
    send_beat(OP_READ, 8'h00, SEL_W'(BYTE_LF));
    send_beat(OP_READ, 8'h00, SEL_MAX_LINE + 1'b1);
    send_beat(OP_SPARE, 8'hFF, '1);
    send_beat(OP_CLEAR, 8'h00, '0);
    send_beat(OP_READ, 8'h00, SEL_W'(8'h41));
    send_beat(OP_READ, 8'h00, SEL_MAX_LINE);

    // Random: text lines with reads, clears and spare opcodes mixed in
    for (n = 0; n < RANDOM_BEATS; n++) begin
      if (n % 64 == 0) begin
        case ($urandom_range(0, 3))
          0:       gap_odds = 0;
          1:       gap_odds = 2;
          2:       gap_odds = 4;
          default: gap_odds = 8;
        endcase
      end
      if (n >= RANDOM_BEATS - TAIL_BEATS) calm <= 1'b1;
      if (!paused && n >= PAUSE_AT) begin
        drain_reads();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1:    sel = SEL_MAX_LINE;
        2:       sel = SEL_W'($urandom_range(NUM_BINS + 1, (1 << SEL_W) - 1));
        default: sel = SEL_W'($urandom_range(0, NUM_BINS - 1));
      endcase
      if (r < 3) begin
        // long unbroken line
        run_len = $urandom_range(20, 60);
        repeat (run_len)
          send_beat(OP_FEED, text_byte(1'b0), SEL_W'($urandom));
        n += run_len - 1;
      end else if (r < 58) begin
        send_beat(OP_FEED, text_byte(1'b1), SEL_W'($urandom));
      end else if (r < 92) begin
        send_beat(OP_READ, 8'($urandom), sel);
      end else if (r < 95) begin
        send_beat(OP_CLEAR, 8'($urandom), SEL_W'($urandom));
      end else begin
        send_beat(OP_SPARE, 8'($urandom), SEL_W'($urandom));
      end
    end

    drain_reads();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (miss_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
